>>> src/bpm_pkg.sv
package bpm_pkg;

  localparam int unsigned DEPTH  = 64;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned POS_W  = 6;
  localparam int unsigned DATA_W = 32;

  localparam logic signed [DATA_W-1:0] POS_INF = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NEG_INF = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes on the config port
  localparam logic REG_WINDOW_START = 1'b0;
  localparam logic REG_WINDOW_END   = 1'b1;

  typedef struct packed {
    logic load;      // input beat taken: write history, clear scan state
    logic issue;     // read one window position
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  typedef struct packed {
    logic last_issue;  // position being read is the window end
    logic out_free;    // output register empty or being drained this cycle
  } status_t;

endpackage

>>> src/bpm_ctrl.sv
module bpm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  bpm_pkg::status_t status,
  output bpm_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.issue    = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read beat is folded in this cycle
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/bpm_datapath.sv
module bpm_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  bpm_pkg::cmd_t                     cmd,
  output bpm_pkg::status_t                  status,
  input  logic [bpm_pkg::POS_W-1:0]         window_start,
  input  logic [bpm_pkg::POS_W-1:0]         window_end,
  input  logic [bpm_pkg::DATA_W-1:0]        sample_time,
  input  logic signed [bpm_pkg::DATA_W-1:0] left_value,
  input  logic signed [bpm_pkg::DATA_W-1:0] right_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bpm_pkg::DATA_W-1:0]        result_time,
  output logic signed [bpm_pkg::DATA_W-1:0] result_value
);

  localparam int unsigned AW = bpm_pkg::ADDR_W;
  localparam int unsigned DW = bpm_pkg::DATA_W;
  localparam int unsigned POS_W_EXT = bpm_pkg::POS_W + 1;

  // history memory: {right, left} per entry, circular
  logic [2*DW-1:0] mem [bpm_pkg::DEPTH];
  logic [bpm_pkg::DEPTH-1:0] written;

  logic [AW-1:0] wp;
  logic [AW-1:0] newest;
  logic [AW-1:0] cnt;
  logic [AW-1:0] end_eff;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] pipe_idx;
  logic          pipe_vld;
  logic [2*DW-1:0] rd_data;
  logic          rd_ok;
  logic [DW-1:0] time_q;

  logic signed [DW-1:0] best;
  logic signed [DW-1:0] prefix;
  logic signed [DW-1:0] lv;
  logic signed [DW-1:0] rv;
  logic signed [DW-1:0] cand;

  // clip end to the history depth
  always_comb begin
    if ({1'b0, window_end} > (POS_W_EXT)'(bpm_pkg::DEPTH - 1)) begin
      end_eff = AW'(bpm_pkg::DEPTH - 1);
    end else begin
      end_eff = AW'(window_end);
    end
  end

  // position i sits at age end-i, i.e. address newest - end + i
  assign rd_addr = newest - end_eff + cnt;

  assign status.last_issue = (cnt == end_eff);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[wp] <= {right_value, left_value};
    end
    if (cmd.issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= '0;
      wp       <= '0;
      newest   <= '0;
      pipe_vld <= 1'b0;
      rd_ok    <= 1'b0;
    end else begin
      pipe_vld <= cmd.issue;
      if (cmd.load) begin
        written[wp] <= 1'b1;
        newest      <= wp;
        wp          <= wp + AW'(1);
      end
      if (cmd.issue) begin
        rd_ok <= written[rd_addr];
      end
    end
  end

  // never-written entries read as the reset fill
  assign lv   = rd_ok ? rd_data[DW-1:0]    : bpm_pkg::POS_INF;
  assign rv   = rd_ok ? rd_data[2*DW-1:DW] : bpm_pkg::NEG_INF;
  assign cand = (prefix < rv) ? prefix : rv;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt    <= '0;
      best   <= bpm_pkg::NEG_INF;
      prefix <= bpm_pkg::POS_INF;
      time_q <= sample_time;
    end else begin
      if (cmd.issue) begin
        cnt      <= cnt + AW'(1);
        pipe_idx <= cnt;
      end
      if (pipe_vld) begin
        if ({1'b0, pipe_idx} >= {1'b0, window_start} && cand > best) begin
          best <= cand;
        end
        if (lv < prefix) begin
          prefix <= lv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_time  <= time_q;
      result_value <= best;
    end
  end

endmodule

>>> src/bounded_precedes_monitor_top.sv
// IDLE takes an input beat, SCAN reads the window, DRAIN folds the last read, and
// DONE loads the output register; no new beat is taken before that. The single compare
// unit walks the window one position a cycle through one registered memory read port.
// The output register frees the input side while a result waits to be taken.
// Reset (rst, synchronous): history reads as left +inf / right -inf, start 0, end 63.
module bounded_precedes_monitor_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // [31:0] sample_time, [63:32] left_value,
                                 // [95:64] right_value
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] result_time, [63:32] result_value
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [5:0]  cfg_wdata
);

  bpm_pkg::cmd_t    cmd;
  bpm_pkg::status_t status;

  logic [bpm_pkg::POS_W-1:0] window_start;
  logic [bpm_pkg::POS_W-1:0] window_end;

  logic [31:0]        result_time;
  logic signed [31:0] result_value;

  // config registers; write only while the block is idle (the block does not enforce this)
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_end   <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        bpm_pkg::REG_WINDOW_START: window_start <= cfg_wdata;
        bpm_pkg::REG_WINDOW_END:   window_end   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bpm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bpm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .window_start (window_start),
    .window_end   (window_end),
    .sample_time  (s_tdata[31:0]),
    .left_value   (s_tdata[63:32]),
    .right_value  (s_tdata[95:64]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .result_time  (result_time),
    .result_value (result_value)
  );

  assign m_tdata = {result_value, result_time};

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 80;   // wait after the last result, with margin
  localparam int unsigned RANDOM_ITEMS = 170;  // per idling phase

  typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

  // one row of the directed table
  typedef struct {
    row_kind_t                 kind;
    logic [31:0]               stamp;
    logic signed [31:0]        left;
    logic signed [31:0]        right;
    bit                        typed;   // expected value given by hand
    logic signed [31:0]        want;
    logic [bpm_pkg::POS_W-1:0] w_start;
    logic [bpm_pkg::POS_W-1:0] w_end;
  } stim_row_t;

  typedef struct packed {
    logic [31:0]        stamp;
    logic signed [31:0] value;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;      // [31:0] sample_time, [63:32] left_value,
                                  // [95:64] right_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;           // [31:0] result_time, [63:32] result_value
  logic        cfg_we = 1'b0;
  logic        cfg_addr = bpm_pkg::REG_WINDOW_START;
  logic [5:0]  cfg_wdata = '0;

  // testbench copy of the block state
  logic signed [31:0] left_hist  [bpm_pkg::DEPTH];  // index 0 = newest
  logic signed [31:0] right_hist [bpm_pkg::DEPTH];
  logic [bpm_pkg::POS_W-1:0] cur_start = '0;
  logic [bpm_pkg::POS_W-1:0] cur_end = 6'd63;

  outcome_t    due_results [$];
  stim_row_t   plan [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned ready_stall_pct = 0;
  logic [31:0] next_stamp = '0;

  bounded_precedes_monitor_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Robustness of "right precedes, guarded by left" over the active window.
  // Walks from the oldest position; prefix holds the min of left over the
  // positions already passed, so position 0 sees +inf.
  function automatic logic signed [31:0] precedes_robustness();
    logic signed [31:0] prefix;
    logic signed [31:0] best;
    logic signed [31:0] cand;
    int unsigned        i;
    int unsigned        age;
    prefix = bpm_pkg::POS_INF;
    best   = bpm_pkg::NEG_INF;
    for (i = 0; i <= cur_end; i++) begin
      age  = cur_end - i;
      cand = (right_hist[age] < prefix) ? right_hist[age] : prefix;
      if (i >= cur_start && cand > best) best = cand;
      if (left_hist[age] < prefix) prefix = left_hist[age];
    end
    return best;
  endfunction

  function automatic void plan_sample(logic [31:0] stamp, logic signed [31:0] left,
                                      logic signed [31:0] right, bit typed,
                                      logic signed [31:0] want);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, stamp: stamp, left: left, right: right, typed: typed,
            want: want, w_start: '0, w_end: '0};
    plan.insert(plan.size(), row);
  endfunction

  function automatic void plan_window(logic [bpm_pkg::POS_W-1:0] w_start,
                                      logic [bpm_pkg::POS_W-1:0] w_end);
    stim_row_t row;
    row = '{kind: ROW_WINDOW, stamp: '0, left: '0, right: '0, typed: 1'b0,
            want: '0, w_start: w_start, w_end: w_end};
    plan.insert(plan.size(), row);
  endfunction

  // often a narrow band around zero so min/max actually compete,
  // plus the infinities and full-range codes
  function automatic logic signed [31:0] pick_robustness();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0:          v = bpm_pkg::POS_INF;
      1:          v = bpm_pkg::NEG_INF;
      2, 3, 4, 5: v = $urandom_range(0, 400) - 200;
      default:    v = $urandom;
    endcase
    return v;
  endfunction

  // Present one sample beat, honouring the sender idle rate; on the accepting
  // edge the history is shifted and the expected result queued.
  task automatic send_sample(logic [31:0] stamp, logic signed [31:0] left,
                             logic signed [31:0] right, bit typed,
                             logic signed [31:0] want);
    int k;
    outcome_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left, stamp};
    do @(posedge clk); while (!s_tready);
    for (k = bpm_pkg::DEPTH - 1; k > 0; k--) begin
      left_hist[k]  = left_hist[k-1];
      right_hist[k] = right_hist[k-1];
    end
    left_hist[0]  = left;
    right_hist[0] = right;
    due.stamp = stamp;
    due.value = typed ? want : precedes_robustness();
    due_results.insert(due_results.size(), due);
  endtask

  // Window registers change only with the block idle: every result back.
  // One result per beat, so nothing can still be in flight once the queue is empty.
  task automatic set_window(logic [bpm_pkg::POS_W-1:0] w_start,
                            logic [bpm_pkg::POS_W-1:0] w_end);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= bpm_pkg::REG_WINDOW_START;
    cfg_wdata <= w_start;
    @(posedge clk);
    cfg_addr  <= bpm_pkg::REG_WINDOW_END;
    cfg_wdata <= w_end;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_start = w_start;
    cur_end   = w_end;
  endtask

  task automatic log_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= ready_stall_pct);
  end

  // result checker: every accepted beat against the oldest expectation
  always @(posedge clk) begin
    outcome_t due;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        log_mismatch("unexpected beat", 32'h0, m_tdata[63:32]);
      end else begin
        due = due_results.pop_front();
        if (m_tdata[31:0] !== due.stamp)
          log_mismatch("result_time", due.stamp, m_tdata[31:0]);
        if (m_tdata[63:32] !== due.value)
          log_mismatch("result_value", due.value, m_tdata[63:32]);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned idle_by_phase  [4];
    int unsigned stall_by_phase [4];
    int unsigned phase;
    int unsigned left_items;
    int unsigned seg_len;
    int unsigned n;
    int          k;
    logic [bpm_pkg::POS_W-1:0] w_start;
    logic [bpm_pkg::POS_W-1:0] w_end;

    // idling phases: none, sender idle, receiver stalling, both
    idle_by_phase  = '{0, 86, 0, 29};
    stall_by_phase = '{0, 0, 86, 29};

    // reset fill: left +inf, right -inf
    for (k = 0; k < bpm_pkg::DEPTH; k++) begin
      left_hist[k]  = bpm_pkg::POS_INF;
      right_hist[k] = bpm_pkg::NEG_INF;
    end

    // Directed table. Defaults after reset: start 0, end 63, so the first
    // beat sees untouched history and the answer is simply its right value.
    plan_sample(32'h0000_0000, bpm_pkg::POS_INF, 32'sh1234_5678, 1'b1, 32'sh1234_5678);
    plan_sample(32'hFFFF_FFFF, bpm_pkg::NEG_INF, bpm_pkg::POS_INF, 1'b0, '0);
    plan_sample(32'h0000_0001, 32'sh0, bpm_pkg::NEG_INF, 1'b0, '0);
    plan_sample(32'hA5A5_A5A5, 32'sh7FFF_FFFE, 32'sh8000_0001, 1'b0, '0);
    plan_sample(32'h5A5A_5A5A, -32'sd1, -32'sd1, 1'b0, '0);
    plan_sample(32'h0000_0002, 32'sd100, 32'sd200, 1'b0, '0);
    // start after end: nothing qualifies, always -inf
    plan_window(6'd10, 6'd5);
    plan_sample(32'h0000_0003, 32'sd5, bpm_pkg::POS_INF, 1'b1, bpm_pkg::NEG_INF);
    plan_sample(32'h0000_0004, bpm_pkg::POS_INF, 32'sd7, 1'b1, bpm_pkg::NEG_INF);
    // single-position window: newest right value with an empty prefix
    plan_window(6'd0, 6'd0);
    plan_sample(32'h0000_0005, bpm_pkg::NEG_INF, -32'sd42, 1'b1, -32'sd42);
    plan_sample(32'h0000_0006, 32'sd1, bpm_pkg::POS_INF, 1'b1, bpm_pkg::POS_INF);
    plan_sample(32'h0000_0007, bpm_pkg::POS_INF, bpm_pkg::NEG_INF, 1'b1,
                bpm_pkg::NEG_INF);
    // widest window, only the newest position counted
    plan_window(6'd63, 6'd63);
    plan_sample(32'h0000_0008, 32'sd3, 32'sd9, 1'b0, '0);
    plan_sample(32'h0000_0009, -32'sd3, 32'sd4, 1'b0, '0);
    // window shrunk at run time, then only the newest position, behind older ones
    plan_window(6'd0, 6'd1);
    plan_sample(32'h0000_000A, 32'sd10, 32'sd20, 1'b0, '0);
    plan_sample(32'h0000_000B, 32'sd15, 32'sd12, 1'b0, '0);
    plan_sample(32'h0000_000C, -32'sd8, 32'sd30, 1'b0, '0);
    plan_window(6'd5, 6'd5);
    plan_sample(32'h0000_000D, 32'sd50, 32'sd60, 1'b0, '0);
    plan_sample(32'h0000_000E, -32'sd50, 32'sd70, 1'b0, '0);
    plan_window(6'd0, 6'd63);
    plan_sample(32'h8000_0000, 32'sd0, 32'sd1, 1'b0, '0);
    plan_sample(32'h7FFF_FFFF, bpm_pkg::NEG_INF, bpm_pkg::POS_INF, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_WINDOW)
        set_window(plan[r].w_start, plan[r].w_end);
      else
        send_sample(plan[r].stamp, plan[r].left, plan[r].right, plan[r].typed,
                    plan[r].want);
    end

    // random part: segments of beats, each under a fresh window setting
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct   = idle_by_phase[phase];
      ready_stall_pct = stall_by_phase[phase];
      left_items = RANDOM_ITEMS;
      while (left_items > 0) begin
        case ($urandom_range(0, 7))
          0: begin w_start = 6'd0;  w_end = 6'd63; end
          1: begin w_start = 6'd0;  w_end = 6'd0;  end
          2: begin w_start = 6'd63; w_end = 6'd63; end
          3: begin w_start = $urandom_range(0, 63); w_end = $urandom_range(0, 63); end
          default: begin
            w_end   = $urandom_range(0, 63);
            w_start = $urandom_range(0, w_end);
          end
        endcase
        set_window(w_start, w_end);
        seg_len = $urandom_range(15, 50);
        if (seg_len > left_items) seg_len = left_items;
        for (n = 0; n < seg_len; n++) begin
          // timestamps mostly climb; now and then a jump anywhere
          if ($urandom_range(0, 9) == 0)
            next_stamp = $urandom;
          else
            next_stamp = next_stamp + $urandom_range(1, 1000);
          send_sample(next_stamp, pick_robustness(), pick_robustness(), 1'b0, '0);
        end
        left_items -= seg_len;
      end
    end

    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
